/* hdl/w2s_pkg.sv */
// ----------------------------------------------------------------------------
// World-to-screen projection package
// Shared types and constants for the projection block.
// ----------------------------------------------------------------------------
package w2s_pkg;

   localparam int unsigned DimWidth = 15;

   typedef enum logic [1:0] {
      FUNC_WR_PROJ = 2'd0,
      FUNC_WR_VIEW = 2'd1,
      FUNC_PROJECT = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]          func;
      logic [3:0]          elem_index;
      logic signed [31:0]  elem_value;
      logic signed [31:0]  point_x;
      logic signed [31:0]  point_y;
      logic signed [31:0]  point_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
      logic signed [31:0] depth;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAT_RD,
      ST_MAT_ACC,
      ST_MAT_WB,
      ST_CLIP_RD,
      ST_CLIP_ACC,
      ST_CLIP_WB,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SCR_X,
      ST_SCR_Y,
      ST_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > 68'sh0_0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -68'sh0_0000_0000_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

/* hdl/w2s_div.sv */
// ----------------------------------------------------------------------------
// Fixed-point divider
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den,
// truncated toward zero and saturated to 32 signed bits. den is positive.
// ----------------------------------------------------------------------------
module w2s_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               done,
   output logic signed [31:0] quot
);
   localparam int NumWidth = 32 + FRAC_BITS;
   localparam int CntWidth = $clog2(NumWidth + 1);

   logic [NumWidth-1:0] dvd_ff, dvd_in;
   logic [NumWidth-1:0] quo_ff, quo_in;
   logic [32:0]         rem_ff, rem_in;
   logic [31:0]         den_ff, den_in;
   logic                neg_ff, neg_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic [32:0]         trial;
   logic [31:0]         mag;
   logic signed [NumWidth+1:0] sq;

   assign mag = num[31] ? 32'(-num) : num;
   assign trial = {rem_ff[31:0], dvd_ff[NumWidth-1]};

   always_comb begin
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         dvd_in  = {mag, {FRAC_BITS{1'b0}}};
         quo_in  = '0;
         rem_in  = '0;
         den_in  = den;
         neg_in  = num[31];
         busy_in = 1'b1;
         cnt_in  = CntWidth'(NumWidth);
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[NumWidth-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NumWidth-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   assign sq = neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
   assign quot = w2s_pkg::sat32(68'(sq));
   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (!reset && done_ff) begin
         assert (!busy_ff) else $error("divider done while still busy");
      end
   end
   property p_start_busy;
      @(posedge clock) disable iff (reset) start |=> busy_ff;
   endproperty
   a_start_busy: assert property (p_start_busy) else $error("divider did not start");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held for two cycles");

endmodule

/* hdl/world_to_screen_projection.sv */
// ----------------------------------------------------------------------------
// World-to-screen projection
// Holds projection and view matrices in one memory, forms their product into
// a scratch area of the same memory, transforms a point and divides by w.
// ----------------------------------------------------------------------------
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_data
//   rsp     | out       | rsp_valid, rsp_ready, rsp_data
//   csr     | in        | csr_we, csr_index, csr_wdata
//
// A matrix write is done in the idle state as its request is taken. A
// project transaction forms 16 product elements of four terms each (read P,
// read V, accumulate) plus a write-back, four clip rows of four terms (read,
// accumulate) plus a write-back, and three divisions in the shared divider.
// The finished result sits in an output register; while it waits, new
// requests are still taken, and a following projection stalls just before
// its screen step until the waiting result has been delivered.
// Reset clears the projection and view matrices (addresses 0..31) with a
// sweep, during which req_ready is low.
// ----------------------------------------------------------------------------
module world_to_screen_projection #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  w2s_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output w2s_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [14:0]       csr_wdata
);
   // Memory map: 0..15 projection, 16..31 view, 32..47 product.
   logic signed [31:0] mem [0:63];
   logic [5:0]         rd_addr, wr_addr;
   logic               wr_en;
   logic signed [31:0] wr_data, rd_q_ff;

   w2s_pkg::state_type state_ff, state_in;
   logic [14:0] width_ff, height_ff;
   logic [5:0]  clr_ff;
   logic        clr_busy_ff;
   w2s_pkg::req_type req_ff;
   logic [3:0]  elem_ff, elem_in;   // product element or clip row
   logic [2:0]  k_ff, k_in;         // term counter
   logic        ph_ff, ph_in;       // read phase within a term
   logic signed [31:0] opa_ff, opa_in;
   logic signed [67:0] acc_ff, acc_in;
   logic signed [31:0] clip_ff [0:3];
   logic signed [31:0] n_ff [0:2];
   logic [1:0]  dsel_ff, dsel_in;
   w2s_pkg::rsp_type out_ff, out_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [63:0] prod;
   logic signed [63:0] fprod;
   logic        div_start, div_done;
   logic signed [31:0] div_quot, div_num, div_den, one_fx;
   logic signed [67:0] scr;
   logic [13:0] half;

   assign one_fx = 32'sd1 <<< FRAC_BITS;
   assign prod   = opa_ff * rd_q_ff;
   assign fprod  = prod >>> FRAC_BITS;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         w2s_pkg::ST_IDLE:
            if (req_valid && req_ready &&
                w2s_pkg::func_type'(req_data.func) == w2s_pkg::FUNC_PROJECT)
               state_in = w2s_pkg::ST_MAT_RD;
         w2s_pkg::ST_MAT_RD:  if (ph_ff) state_in = w2s_pkg::ST_MAT_ACC;
         w2s_pkg::ST_MAT_ACC:
            state_in = (k_ff == 3'd3) ? w2s_pkg::ST_MAT_WB : w2s_pkg::ST_MAT_RD;
         w2s_pkg::ST_MAT_WB:
            state_in = (elem_ff == 4'd15) ? w2s_pkg::ST_CLIP_RD : w2s_pkg::ST_MAT_RD;
         w2s_pkg::ST_CLIP_RD: state_in = w2s_pkg::ST_CLIP_ACC;
         w2s_pkg::ST_CLIP_ACC:
            state_in = (k_ff == 3'd3) ? w2s_pkg::ST_CLIP_WB : w2s_pkg::ST_CLIP_RD;
         w2s_pkg::ST_CLIP_WB:
            state_in = (elem_ff == 4'd3) ? w2s_pkg::ST_DIV_START : w2s_pkg::ST_CLIP_RD;
         w2s_pkg::ST_DIV_START: state_in = w2s_pkg::ST_DIV_WAIT;
         w2s_pkg::ST_DIV_WAIT:
            if (div_done)
               state_in = (dsel_ff == 2'd2) ? w2s_pkg::ST_SCR_X : w2s_pkg::ST_DIV_START;
         // The output register is rewritten from here on, so wait for it.
         w2s_pkg::ST_SCR_X: if (!rsp_valid_ff) state_in = w2s_pkg::ST_SCR_Y;
         w2s_pkg::ST_SCR_Y: state_in = w2s_pkg::ST_OUT;
         w2s_pkg::ST_OUT:   state_in = w2s_pkg::ST_IDLE;
         default:           state_in = w2s_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      elem_in = elem_ff;
      k_in    = k_ff;
      ph_in   = ph_ff;
      opa_in  = opa_ff;
      acc_in  = acc_ff;
      dsel_in = dsel_ff;
      out_in  = out_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      div_start = 1'b0;
      half  = '0;
      scr   = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (clr_busy_ff) begin
         wr_en = 1'b1;
         wr_addr = clr_ff;
      end
      unique case (state_ff)
         w2s_pkg::ST_IDLE: begin
            elem_in = '0;
            k_in = '0;
            ph_in = 1'b0;
            acc_in = '0;
            dsel_in = '0;
            if (req_valid && req_ready && !clr_busy_ff) begin
               wr_data = req_data.elem_value;
               if (w2s_pkg::func_type'(req_data.func) == w2s_pkg::FUNC_WR_PROJ) begin
                  wr_en = 1'b1;
                  wr_addr = {2'b00, req_data.elem_index};
               end else if (w2s_pkg::func_type'(req_data.func) ==
                            w2s_pkg::FUNC_WR_VIEW) begin
                  wr_en = 1'b1;
                  wr_addr = {2'b01, req_data.elem_index};
               end
            end
         end
         w2s_pkg::ST_MAT_RD: begin
            // Phase 0 reads P[r][k]; phase 1 latches it and reads V[k][c].
            if (!ph_ff) begin
               rd_addr = {2'b00, elem_ff[3:2], k_ff[1:0]};
               ph_in = 1'b1;
            end else begin
               rd_addr = {2'b01, k_ff[1:0], elem_ff[1:0]};
               ph_in = 1'b0;
               opa_in = rd_q_ff;
            end
         end
         w2s_pkg::ST_MAT_ACC: begin
            acc_in = acc_ff + 68'(fprod);
            k_in = k_ff + 3'd1;
         end
         w2s_pkg::ST_MAT_WB: begin
            wr_en = 1'b1;
            wr_addr = {2'b10, elem_ff};
            wr_data = w2s_pkg::sat32(acc_ff);
            acc_in = '0;
            k_in = '0;
            elem_in = elem_ff + 4'd1;
         end
         w2s_pkg::ST_CLIP_RD: begin
            // Term k reads M[r][k]; the point coordinate, or one for the fourth term, is the other factor.
            rd_addr = {2'b10, elem_ff[1:0], k_ff[1:0]};
            unique case (k_ff[1:0])
               2'd0: opa_in = req_ff.point_x;
               2'd1: opa_in = req_ff.point_y;
               2'd2: opa_in = req_ff.point_z;
               default: opa_in = one_fx;
            endcase
         end
         w2s_pkg::ST_CLIP_ACC: begin
            // The fourth column enters unscaled, which equals one times it.
            acc_in = acc_ff + ((k_ff == 3'd3) ? 68'(rd_q_ff) : 68'(fprod));
            k_in = k_ff + 3'd1;
         end
         w2s_pkg::ST_CLIP_WB: begin
            acc_in = '0;
            k_in = '0;
            elem_in = elem_ff + 4'd1;
         end
         w2s_pkg::ST_DIV_START: div_start = 1'b1;
         w2s_pkg::ST_DIV_WAIT:
            if (div_done) dsel_in = dsel_ff + 2'd1;
         w2s_pkg::ST_SCR_X: begin
            if (!rsp_valid_ff) begin
               half = width_ff[14:1];
               scr = 68'($signed({1'b0, half})) * 68'(n_ff[0]) + 68'(n_ff[0]) +
                     (68'($signed({1'b0, half})) <<< FRAC_BITS);
               out_in.screen_x = w2s_pkg::sat32(scr);
               out_in.depth = n_ff[2];
            end
         end
         w2s_pkg::ST_SCR_Y: begin
            half = height_ff[14:1];
            scr = -(68'($signed({1'b0, half})) * 68'(n_ff[1])) + 68'(n_ff[1]) +
                  (68'($signed({1'b0, half})) <<< FRAC_BITS);
            out_in.screen_y = w2s_pkg::sat32(scr);
         end
         w2s_pkg::ST_OUT: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   assign div_num = clip_ff[dsel_ff];
   assign div_den = (clip_ff[3] > 32'sd0) ? clip_ff[3] : one_fx;

   w2s_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= w2s_pkg::ST_IDLE;
         width_ff <= 15'd1920;
         height_ff <= 15'd1080;
         clr_ff <= '0;
         clr_busy_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (clr_busy_ff) begin
            clr_ff <= clr_ff + 6'd1;
            if (clr_ff == 6'd31) clr_busy_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (w2s_pkg::csr_index_type'(csr_index))
               w2s_pkg::CSR_WIDTH:  width_ff <= csr_wdata;
               w2s_pkg::CSR_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      elem_ff <= elem_in;
      k_ff <= k_in;
      ph_ff <= ph_in;
      opa_ff <= opa_in;
      acc_ff <= acc_in;
      dsel_ff <= dsel_in;
      out_ff <= out_in;
      if (state_ff == w2s_pkg::ST_IDLE && req_valid && req_ready) req_ff <= req_data;
      if (state_ff == w2s_pkg::ST_CLIP_WB) clip_ff[elem_ff[1:0]] <= w2s_pkg::sat32(acc_ff);
      if (state_ff == w2s_pkg::ST_DIV_WAIT && div_done) n_ff[dsel_ff] <= div_quot;
   end

   assign req_ready = (state_ff == w2s_pkg::ST_IDLE) && !clr_busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = out_ff;

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_ready) else $error("request taken during clear");
   a_out_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == w2s_pkg::ST_OUT |-> !rsp_valid_ff) else $error("result overwritten");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == w2s_pkg::ST_DIV_WAIT) else $error("stray divider result");

endmodule
